// ===== rtl/scpr_pkg.sv =====
package scpr_pkg;

	localparam int COST_W      = 16;
	localparam int IDX_W       = 8;
	localparam int CNT_W       = 9;
	localparam int MAX_DISP    = 256;
	localparam int CONF_W      = 17;
	localparam int QUO_W       = 16;
	localparam int DEN_W       = 19;
	localparam int REM_W       = DEN_W + 1;
	localparam int DIV_STEPS   = QUO_W;
	localparam int STEP_W      = $clog2(DIV_STEPS);
	localparam int COUNT_RESET = 64;
	localparam int ADDR_W      = 3;
	localparam int DATA_W      = 32;

	localparam logic [ADDR_W-1:0] REG_DISPARITY_COUNT = ADDR_W'(0);

	// controller to datapath
	typedef struct packed {
		logic take;
		logic load;
		logic step;
		logic emit;
	} scpr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} scpr_status_t;

endpackage

// ===== rtl/stereo_cost_peak_ratio_confidence_top.sv =====
// Peak-ratio stereo confidence. Costs of one pixel stream in on the input
// channel, one disparity per item in order 0, 1, 2, ..., disparity_count of
// them (register at address 0, clamped to 2..256, reset 64). One result per
// pixel follows the last cost: confidence = min(second/smallest, 5)/5 with 16
// fraction bits (65536 = 1.0, 0 when the smallest cost is zero), the first
// best disparity, its cost and the costs either side, which are zero unless
// neighbours_valid. Costs are taken at one per cycle unless held off. The ratio
// comes from a one-bit-per-cycle divider whose quotient is then registered into
// the result register; the divider runs alongside the scan of the next pixel,
// the last cost of a pixel being held off while the divider or a result
// waiting at the output is still occupied.
module stereo_cost_peak_ratio_confidence_top
	import scpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [COST_W-1:0] cost,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CONF_W-1:0] confidence,
	output logic [IDX_W-1:0]  best_disparity,
	output logic [COST_W-1:0] lowest_cost,
	output logic [COST_W-1:0] cost_before,
	output logic [COST_W-1:0] cost_after,
	output logic              neighbours_valid
);

	logic [CNT_W-1:0] count_q;
	logic             sel_count;
	scpr_cmd_t        cmd;
	scpr_status_t     status;

	assign pready    = 1'b1;
	assign sel_count = ({paddr[ADDR_W-1:2], 2'b00} == REG_DISPARITY_COUNT);
	assign prdata    = sel_count ? DATA_W'(count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(COUNT_RESET);
		end else if (psel && penable && pwrite && pready && sel_count) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	scpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	scpr_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.disparity_count  (count_q),
		.cost             (cost),
		.confidence       (confidence),
		.best_disparity   (best_disparity),
		.lowest_cost      (lowest_cost),
		.cost_before      (cost_before),
		.cost_after       (cost_after),
		.neighbours_valid (neighbours_valid)
	);

endmodule

// ===== rtl/scpr_ctrl.sv =====
module scpr_ctrl
	import scpr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  logic         out_stall,
	input  scpr_status_t status,
	output scpr_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_FREE,
		ST_RUN,
		ST_HOLD
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;

	// the last item of a pixel waits while the divider is occupied
	assign in_stall  = status.last && (state_q != ST_FREE);
	assign cmd.take  = in_valid && !in_stall;
	assign cmd.load  = cmd.take && status.last;
	assign cmd.step  = (state_q == ST_RUN);
	assign cmd.emit  = (state_q == ST_HOLD) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FREE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_FREE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (cmd.emit) begin
						state_q <= ST_FREE;
					end
				end
				default: begin
					state_q <= ST_FREE;
				end
			endcase
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/scpr_dp.sv =====
module scpr_dp
	import scpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  scpr_cmd_t         cmd,
	output scpr_status_t      status,
	input  logic [CNT_W-1:0]  disparity_count,
	input  logic [COST_W-1:0] cost,
	output logic [CONF_W-1:0] confidence,
	output logic [IDX_W-1:0]  best_disparity,
	output logic [COST_W-1:0] lowest_cost,
	output logic [COST_W-1:0] cost_before,
	output logic [COST_W-1:0] cost_after,
	output logic              neighbours_valid
);

	// scan state
	logic [IDX_W-1:0]  d_q;
	logic [COST_W-1:0] min_q, second_q, prev_q, left_q, right_q;
	logic [IDX_W-1:0]  min_idx_q;
	logic              rc_q;

	logic [COST_W-1:0] min_n, second_n, left_n, right_n;
	logic [IDX_W-1:0]  min_idx_n;
	logic              rc_n;
	logic [CNT_W-1:0]  n_eff;
	logic [CNT_W-1:0]  d_next;
	logic              nb_valid_n;

	// divider
	logic [REM_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [QUO_W-1:0]  quo_q;
	logic              zero_q, sat_q;
	logic [IDX_W-1:0]  best_q;
	logic [COST_W-1:0] dmin_q, before_q, after_q;
	logic              nbv_q;
	logic [DEN_W-1:0]  den_n;
	logic [REM_W-1:0]  shifted;

	// result register
	logic [CONF_W-1:0] conf_q;
	logic [IDX_W-1:0]  res_best_q;
	logic [COST_W-1:0] res_min_q, res_before_q, res_after_q;
	logic              res_nbv_q;

	always_comb begin
		if (disparity_count < CNT_W'(2)) begin
			n_eff = CNT_W'(2);
		end else if (disparity_count > CNT_W'(MAX_DISP)) begin
			n_eff = CNT_W'(MAX_DISP);
		end else begin
			n_eff = disparity_count;
		end
	end

	assign d_next      = {1'b0, d_q} + 1'b1;
	assign status.last = (d_next >= n_eff);

	always_comb begin
		min_n     = min_q;
		second_n  = second_q;
		left_n    = left_q;
		right_n   = right_q;
		min_idx_n = min_idx_q;
		rc_n      = rc_q;
		if (d_q == '0) begin
			min_n     = cost;
			min_idx_n = '0;
			second_n  = '1;
			left_n    = '0;
			right_n   = '0;
			rc_n      = 1'b0;
		end else begin
			if (!rc_q) begin
				right_n = cost;
			end
			rc_n = 1'b1;
			if (cost < min_q) begin
				second_n  = min_q;
				min_n     = cost;
				min_idx_n = d_q;
				left_n    = prev_q;
				rc_n      = 1'b0;
			end else if (cost < second_q) begin
				second_n = cost;
			end
		end
	end

	assign nb_valid_n = (min_idx_n != '0) && (({1'b0, min_idx_n} + 1'b1) < n_eff);
	assign den_n      = {min_n, 2'b00} + DEN_W'(min_n);
	assign shifted    = {rem_q[REM_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (cmd.take) begin
			d_q <= status.last ? '0 : d_next[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			min_q     <= min_n;
			second_q  <= second_n;
			left_q    <= left_n;
			right_q   <= right_n;
			min_idx_q <= min_idx_n;
			rc_q      <= rc_n;
			prev_q    <= cost;
		end
		if (cmd.load) begin
			rem_q    <= REM_W'(second_n);
			den_q    <= den_n;
			quo_q    <= '0;
			zero_q   <= (min_n == '0);
			sat_q    <= (DEN_W'(second_n) >= den_n);
			best_q   <= min_idx_n;
			dmin_q   <= min_n;
			before_q <= nb_valid_n ? left_n : '0;
			after_q  <= nb_valid_n ? right_n : '0;
			nbv_q    <= nb_valid_n;
		end else if (cmd.step) begin
			if (shifted >= {1'b0, den_q}) begin
				rem_q <= shifted - {1'b0, den_q};
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			if (zero_q) begin
				conf_q <= '0;
			end else if (sat_q) begin
				conf_q <= {1'b1, {QUO_W{1'b0}}};
			end else begin
				conf_q <= {1'b0, quo_q};
			end
			res_best_q   <= best_q;
			res_min_q    <= dmin_q;
			res_before_q <= before_q;
			res_after_q  <= after_q;
			res_nbv_q    <= nbv_q;
		end
	end

	assign confidence       = conf_q;
	assign best_disparity   = res_best_q;
	assign lowest_cost      = res_min_q;
	assign cost_before      = res_before_q;
	assign cost_after       = res_after_q;
	assign neighbours_valid = res_nbv_q;

endmodule
